/* rtl/kra_pkg.sv */
// Shared constants and types for the key remap / auto-repeat block.
// Used by kra_keymap, kra_repeat and key_remap_autorepeat_core.
package kra_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int ID_W           = 5;
    localparam int EVT_W          = 5;
    localparam int CODE_W         = 10;
    localparam int VAL_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LAYOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd2;

    localparam logic [CFG_W-1:0] DELAY_RST  = 16'd300;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd80;

    localparam logic             REQ_KEY     = 1'b0;
    localparam logic             REQ_TICK    = 1'b1;
    localparam logic [EVT_W-1:0] EVT_KEY     = 5'd1;
    localparam logic [VAL_W-1:0] VAL_RELEASE = 2'd0;
    localparam logic [VAL_W-1:0] VAL_PRESS   = 2'd1;

    localparam logic [ID_W-1:0] ID_UP    = 5'd11;
    localparam logic [ID_W-1:0] ID_RIGHT = 5'd14;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] id;
        logic            press;
    } t_key_evt;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            pressed;
        logic            is_repeat;
    } t_result;

endpackage

/* rtl/kra_keymap.sv */
// Key code to dense key id lookup for both layouts, plus event qualification.
// Depends on kra_pkg.
module kra_keymap (
    input  logic                       i_layout,
    input  logic [kra_pkg::EVT_W-1:0]  i_event_type,
    input  logic [kra_pkg::CODE_W-1:0] i_key_code,
    input  logic [kra_pkg::VAL_W-1:0]  i_key_value,
    output kra_pkg::t_key_evt          o_evt
);

    logic                     mapped;
    logic [kra_pkg::ID_W-1:0] id;

    always_comb begin
        mapped = 1'b1;
        id     = '0;
        case (i_key_code)
            10'd57:  id = 5'd0;
            10'd29:  id = 5'd1;
            10'd42:  id = 5'd2;
            10'd56:  id = 5'd3;
            10'd15:  id = i_layout ? 5'd4 : 5'd6;
            10'd14:  id = i_layout ? 5'd5 : 5'd7;
            10'd18:  id = i_layout ? 5'd6 : 5'd4;
            10'd20:  id = i_layout ? 5'd7 : 5'd5;
            10'd97:  id = 5'd8;
            10'd28:  id = 5'd9;
            10'd1:   id = 5'd10;
            10'd103: id = 5'd11;
            10'd108: id = 5'd12;
            10'd105: id = 5'd13;
            10'd106: id = 5'd14;
            10'd115: id = 5'd15;
            10'd114: id = 5'd16;
            default: mapped = 1'b0;
        endcase
    end

    always_comb begin
        o_evt.hit   = mapped && (i_event_type == kra_pkg::EVT_KEY) &&
                      ((i_key_value == kra_pkg::VAL_PRESS) ||
                       (i_key_value == kra_pkg::VAL_RELEASE));
        o_evt.id    = id;
        o_evt.press = (i_key_value == kra_pkg::VAL_PRESS);
    end

endmodule

/* rtl/kra_repeat.sv */
// Hold tracking and saturating repeat timers; builds the result of one request.
// Depends on kra_pkg.
module kra_repeat #(
    parameter int TIMER_BITS = kra_pkg::TIMER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic                      i_is_tick,
    input  kra_pkg::t_key_evt         i_evt,
    input  logic [kra_pkg::CFG_W-1:0] i_delay,
    input  logic [kra_pkg::CFG_W-1:0] i_period,
    output kra_pkg::t_result          o_res
);

    localparam int CMP_W = (TIMER_BITS > kra_pkg::CFG_W) ? TIMER_BITS : kra_pkg::CFG_W;
    typedef logic [CMP_W-1:0] t_cmp;

    logic                     r_hold;
    logic [kra_pkg::ID_W-1:0] r_held_id;
    logic [TIMER_BITS-1:0]    r_elapsed;
    logic [TIMER_BITS-1:0]    r_since;

    logic                     n_hold;
    logic [kra_pkg::ID_W-1:0] n_held_id;
    logic [TIMER_BITS-1:0]    n_elapsed;
    logic [TIMER_BITS-1:0]    n_since;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [TIMER_BITS-1:0] since_inc;
    logic                  rep_due;
    logic                  is_dir;

    always_comb begin
        elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        since_inc   = (&r_since) ? r_since : r_since + 1'b1;
        rep_due     = r_hold && (t_cmp'(elapsed_inc) >= t_cmp'(i_delay)) &&
                      (t_cmp'(since_inc) >= t_cmp'(i_period));
        is_dir      = (i_evt.id >= kra_pkg::ID_UP) && (i_evt.id <= kra_pkg::ID_RIGHT);

        n_hold    = r_hold;
        n_held_id = r_held_id;
        n_elapsed = r_elapsed;
        n_since   = r_since;
        o_res     = '0;

        if (i_is_tick) begin
            n_elapsed       = elapsed_inc;
            n_since         = rep_due ? '0 : since_inc;
            o_res.valid     = rep_due;
            o_res.id        = r_held_id;
            o_res.pressed   = 1'b1;
            o_res.is_repeat = 1'b1;
        end else if (i_evt.hit) begin
            o_res.valid   = 1'b1;
            o_res.id      = i_evt.id;
            o_res.pressed = i_evt.press;
            if (i_evt.press) begin
                if (is_dir) begin
                    n_hold    = 1'b1;
                    n_held_id = i_evt.id;
                    n_elapsed = '0;
                    n_since   = '0;
                end
            end else if (r_hold && (r_held_id == i_evt.id)) begin
                n_hold = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= 1'b0;
            r_held_id <= '0;
            r_elapsed <= '0;
            r_since   <= '0;
        end else if (i_fire) begin
            r_hold    <= n_hold;
            r_held_id <= n_held_id;
            r_elapsed <= n_elapsed;
            r_since   <= n_since;
        end
    end

endmodule

/* rtl/key_remap_autorepeat_core.sv */
// Top level of the key remap / auto-repeat block: config registers,
// request register and result register. Depends on kra_pkg, kra_keymap, kra_repeat.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall): either a key event (evdev type,
//   code, value) or a one-millisecond tick, selected by i_req_type.
//   Result channel (o_out_valid / i_out_stall): at most one key event per
//   request: mapped key id, press/release flag and an auto-repeat flag.
//   Requests that map to nothing or that do not trigger a repeat give no result.
//   Config port (i_cfg_wen / i_cfg_index / i_cfg_wdata): layout select, repeat
//   delay and repeat period; write only while the block is idle.
//   A taken request passes through the request register, then the result register.
//   Throughput: one request per cycle while the receiver does not stall, set by
//   the request and result registers each holding one entry.
//   Reset: layout 0, delay 300, period 80, no key held, timers zero.
//   Receiver stall: the result register holds; the request register then
//   holds too and o_in_stall rises while it is full.
module key_remap_autorepeat_core #(
    parameter int TIMER_BITS = kra_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [kra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kra_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [kra_pkg::EVT_W-1:0]     i_event_type,
    input  logic [kra_pkg::CODE_W-1:0]    i_key_code,
    input  logic [kra_pkg::VAL_W-1:0]     i_key_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kra_pkg::ID_W-1:0]      o_key_id,
    output logic                          o_pressed,
    output logic                          o_is_repeat
);

    logic                        r_layout;
    logic [kra_pkg::CFG_W-1:0]   r_delay;
    logic [kra_pkg::CFG_W-1:0]   r_period;

    logic                        r_in_valid;
    logic                        r_req_type;
    logic [kra_pkg::EVT_W-1:0]   r_event_type;
    logic [kra_pkg::CODE_W-1:0]  r_key_code;
    logic [kra_pkg::VAL_W-1:0]   r_key_value;

    kra_pkg::t_result            r_res;

    logic                        fire;
    logic                        in_take;
    kra_pkg::t_key_evt           evt;
    kra_pkg::t_result            res;

    assign fire       = r_in_valid && (!r_res.valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= 1'b0;
            r_delay  <= kra_pkg::DELAY_RST;
            r_period <= kra_pkg::PERIOD_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                kra_pkg::CFG_KEY_LAYOUT:    r_layout <= i_cfg_wdata[0];
                kra_pkg::CFG_REPEAT_DELAY:  r_delay  <= i_cfg_wdata;
                kra_pkg::CFG_REPEAT_PERIOD: r_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type   <= i_req_type;
            r_event_type <= i_event_type;
            r_key_code   <= i_key_code;
            r_key_value  <= i_key_value;
        end
    end

    kra_keymap u_keymap (
        .i_layout     (r_layout),
        .i_event_type (r_event_type),
        .i_key_code   (r_key_code),
        .i_key_value  (r_key_value),
        .o_evt        (evt)
    );

    kra_repeat #(
        .TIMER_BITS (TIMER_BITS)
    ) u_repeat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_is_tick (r_req_type == kra_pkg::REQ_TICK),
        .i_evt     (evt),
        .i_delay   (r_delay),
        .i_period  (r_period),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (fire) begin
            r_res <= res;
        end else if (r_res.valid && !i_out_stall) begin
            r_res.valid <= 1'b0;
        end
    end

    assign o_out_valid = r_res.valid;
    assign o_key_id    = r_res.id;
    assign o_pressed   = r_res.pressed;
    assign o_is_repeat = r_res.is_repeat;

endmodule

/* sim/key_remap_autorepeat_checker.sv */
// Checker for key_remap_autorepeat_core: watches the config port and both channels,
// predicts each key event from its own copy of the layout, timers and hold state.
// Depends on kra_pkg; instantiated beside the block by key_remap_autorepeat_core_test.
module key_remap_autorepeat_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [kra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kra_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [kra_pkg::EVT_W-1:0]     i_event_type,
    input  logic [kra_pkg::CODE_W-1:0]    i_key_code,
    input  logic [kra_pkg::VAL_W-1:0]     i_key_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [kra_pkg::ID_W-1:0]      i_key_id,
    input  logic                          i_pressed,
    input  logic                          i_is_repeat,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [kra_pkg::ID_W-1:0] id;
        logic                     pressed;
        logic                     is_repeat;
    } t_key_event;

    localparam logic [kra_pkg::ID_W-1:0]  NO_KEY_ID = '1;
    localparam logic [kra_pkg::CFG_W-1:0] TIMER_MAX = '1;

    logic                      alt_layout;
    logic [kra_pkg::CFG_W-1:0] repeat_delay;
    logic [kra_pkg::CFG_W-1:0] repeat_period;
    logic                      hold_on;
    logic [kra_pkg::ID_W-1:0]  held_key;
    logic [kra_pkg::CFG_W-1:0] held_ticks;
    logic [kra_pkg::CFG_W-1:0] since_repeat;

    t_key_event key_events_due[$];

    function automatic logic [kra_pkg::ID_W-1:0] lookup_key_id(
        input logic [kra_pkg::CODE_W-1:0] code
    );
        case (code)
            10'd57:  return 5'd0;
            10'd29:  return 5'd1;
            10'd42:  return 5'd2;
            10'd56:  return 5'd3;
            10'd15:  return alt_layout ? 5'd4 : 5'd6;
            10'd14:  return alt_layout ? 5'd5 : 5'd7;
            10'd18:  return alt_layout ? 5'd6 : 5'd4;
            10'd20:  return alt_layout ? 5'd7 : 5'd5;
            10'd97:  return 5'd8;
            10'd28:  return 5'd9;
            10'd1:   return 5'd10;
            10'd103: return 5'd11;
            10'd108: return 5'd12;
            10'd105: return 5'd13;
            10'd106: return 5'd14;
            10'd115: return 5'd15;
            10'd114: return 5'd16;
            default: return NO_KEY_ID;
        endcase
    endfunction

    function automatic void predict_key_event(
        input logic                       req,
        input logic [kra_pkg::EVT_W-1:0]  etype,
        input logic [kra_pkg::CODE_W-1:0] code,
        input logic [kra_pkg::VAL_W-1:0]  val
    );
        logic [kra_pkg::ID_W-1:0] id;
        if (req == kra_pkg::REQ_TICK) begin
            if (held_ticks != TIMER_MAX) held_ticks++;
            if (since_repeat != TIMER_MAX) since_repeat++;
            if (hold_on && held_ticks >= repeat_delay && since_repeat >= repeat_period) begin
                since_repeat = '0;
                key_events_due.push_back(t_key_event'{held_key, 1'b1, 1'b1});
            end
        end else if (etype == kra_pkg::EVT_KEY &&
                     (val == kra_pkg::VAL_PRESS || val == kra_pkg::VAL_RELEASE)) begin
            id = lookup_key_id(code);
            if (id != NO_KEY_ID) begin
                if (val == kra_pkg::VAL_PRESS) begin
                    if (id >= kra_pkg::ID_UP && id <= kra_pkg::ID_RIGHT) begin
                        hold_on      = 1'b1;
                        held_key     = id;
                        held_ticks   = '0;
                        since_repeat = '0;
                    end
                    key_events_due.push_back(t_key_event'{id, 1'b1, 1'b0});
                end else begin
                    if (hold_on && held_key == id) hold_on = 1'b0;
                    key_events_due.push_back(t_key_event'{id, 1'b0, 1'b0});
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_key_event want;
        if (!i_rst_n) begin
            alt_layout    = 1'b0;
            repeat_delay  = kra_pkg::DELAY_RST;
            repeat_period = kra_pkg::PERIOD_RST;
            hold_on       = 1'b0;
            held_key      = '0;
            held_ticks    = '0;
            since_repeat  = '0;
            o_fail_count  = 0;
            key_events_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (key_events_due.size() == 0) begin
                    $display("%0t: result with none due: id=%0d pressed=%0b repeat=%0b",
                             $time, i_key_id, i_pressed, i_is_repeat);
                    o_fail_count++;
                end else begin
                    want = key_events_due.pop_front();
                    if (want.id != i_key_id || want.pressed != i_pressed ||
                        want.is_repeat != i_is_repeat) begin
                        $display({"%0t: mismatch: expected id=%0d pressed=%0b repeat=%0b,",
                                  " got id=%0d pressed=%0b repeat=%0b"},
                                 $time, want.id, want.pressed, want.is_repeat,
                                 i_key_id, i_pressed, i_is_repeat);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    kra_pkg::CFG_KEY_LAYOUT:    alt_layout    = i_cfg_wdata[0];
                    kra_pkg::CFG_REPEAT_DELAY:  repeat_delay  = i_cfg_wdata;
                    kra_pkg::CFG_REPEAT_PERIOD: repeat_period = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_key_event(i_req_type, i_event_type, i_key_code, i_key_value);
            end
        end
        o_pending <= key_events_due.size();
    end

endmodule

/* sim/key_remap_autorepeat_core_test.sv */
// Top of the key_remap_autorepeat_core testbench: clock, reset, request and config
// stimulus, receiver stalls and the verdict. Depends on kra_pkg and the checker module.
module key_remap_autorepeat_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [kra_pkg::EVT_W-1:0]  t_evt;
    typedef logic [kra_pkg::CODE_W-1:0] t_code;
    typedef logic [kra_pkg::VAL_W-1:0]  t_val;
    typedef logic [kra_pkg::CFG_W-1:0]  t_cfg;

    localparam int                            CYCLE_LIMIT  = 100_000;
    localparam int                            HOLD_CYCLES  = 200;
    localparam int                            DRAIN_CYCLES = 4;
    localparam logic [kra_pkg::CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_wen    = 1'b0;
    logic [kra_pkg::CFG_IDX_W-1:0] i_cfg_index  = kra_pkg::CFG_KEY_LAYOUT;
    logic [kra_pkg::CFG_W-1:0]     i_cfg_wdata  = '0;
    logic                          i_in_valid   = 1'b0;
    logic                          i_req_type   = kra_pkg::REQ_KEY;
    logic [kra_pkg::EVT_W-1:0]     i_event_type = '0;
    logic [kra_pkg::CODE_W-1:0]    i_key_code   = '0;
    logic [kra_pkg::VAL_W-1:0]     i_key_value  = '0;
    logic                          i_out_stall  = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [kra_pkg::ID_W-1:0]      o_key_id;
    logic                          o_pressed;
    logic                          o_is_repeat;

    int fail_count;
    int pending;
    int send_idle     = 29;
    int recv_idle     = 87;
    int requests_sent = 0;
    int cycle_count   = 0;
    int hold_count    = 0;
    bit hold_off_req  = 1'b0;

    int dir_codes[4]     = '{103, 108, 105, 106};
    int mapped_codes[17] = '{57, 29, 42, 56, 15, 14, 18, 20, 97, 28, 1,
                             103, 108, 105, 106, 115, 114};

    key_remap_autorepeat_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_event_type (i_event_type),
        .i_key_code   (i_key_code),
        .i_key_value  (i_key_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_id     (o_key_id),
        .o_pressed    (o_pressed),
        .o_is_repeat  (o_is_repeat)
    );

    key_remap_autorepeat_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_event_type (i_event_type),
        .i_key_code   (i_key_code),
        .i_key_value  (i_key_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_key_id     (o_key_id),
        .i_pressed    (o_pressed),
        .i_is_repeat  (o_is_repeat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("key_remap_autorepeat_core verification failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                hold_count++;
                if (hold_count >= HOLD_CYCLES) begin
                    hold_off_req = 1'b0;
                    hold_count   = 0;
                end
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic send_request(
        input logic  req,
        input t_evt  etype,
        input t_code code,
        input t_val  val
    );
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_event_type <= etype;
        i_key_code   <= code;
        i_key_value  <= val;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(kra_pkg::REQ_TICK, t_evt'($urandom_range(31)),
                     t_code'($urandom_range(767)), t_val'($urandom_range(3)));
    endtask

    task automatic send_key(input int code, input t_val val);
        send_request(kra_pkg::REQ_KEY, kra_pkg::EVT_KEY, t_code'(code), val);
    endtask

    // hold the sender until every pending request has drained
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(
        input logic layout,
        input t_cfg delay_ticks,
        input t_cfg period_ticks
    );
        drain();
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= kra_pkg::CFG_KEY_LAYOUT;
        i_cfg_wdata <= {{(kra_pkg::CFG_W-1){1'b0}}, layout};
        @(posedge i_clk);
        i_cfg_index <= kra_pkg::CFG_REPEAT_DELAY;
        i_cfg_wdata <= delay_ticks;
        @(posedge i_clk);
        i_cfg_index <= kra_pkg::CFG_REPEAT_PERIOD;
        i_cfg_wdata <= period_ticks;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic random_traffic(input int target);
        int pick;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (pick < 50) begin
                send_key(dir_codes[$urandom_range(3)], kra_pkg::VAL_PRESS);
            end else if (pick < 60) begin
                send_key(dir_codes[$urandom_range(3)], kra_pkg::VAL_RELEASE);
            end else if (pick < 82) begin
                send_key(mapped_codes[$urandom_range(16)], t_val'($urandom_range(1)));
            end else begin
                send_request(kra_pkg::REQ_KEY, t_evt'($urandom_range(31)),
                             t_code'($urandom_range(767)), t_val'($urandom_range(3)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= CFG_SPARE;
        i_cfg_wdata <= '1;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;

        send_request(kra_pkg::REQ_TICK, '1, '1, '1);
        send_request(kra_pkg::REQ_KEY, 5'd0, 10'd103, kra_pkg::VAL_PRESS);
        send_request(kra_pkg::REQ_KEY, '1, 10'd103, kra_pkg::VAL_PRESS);
        send_key(103, 2'd2);
        send_key(103, 2'd3);
        send_key(0, kra_pkg::VAL_PRESS);
        send_key(767, kra_pkg::VAL_PRESS);
        send_key(2, kra_pkg::VAL_RELEASE);
        send_key(103, kra_pkg::VAL_PRESS);
        send_key(57, kra_pkg::VAL_PRESS);
        send_key(108, kra_pkg::VAL_RELEASE);
        send_key(15, kra_pkg::VAL_PRESS);
        send_key(14, kra_pkg::VAL_PRESS);
        send_key(18, kra_pkg::VAL_PRESS);
        send_key(20, kra_pkg::VAL_PRESS);
        send_key(103, kra_pkg::VAL_RELEASE);
        send_tick();
        send_key(1, kra_pkg::VAL_PRESS);
        send_key(114, kra_pkg::VAL_RELEASE);

        configure(1'b1, '0, '0);
        send_key(106, kra_pkg::VAL_PRESS);
        send_tick();
        send_tick();
        send_key(15, kra_pkg::VAL_PRESS);
        send_key(18, kra_pkg::VAL_PRESS);
        configure(1'b0, '0, '0);
        send_tick();
        send_key(15, kra_pkg::VAL_PRESS);
        send_key(106, kra_pkg::VAL_RELEASE);
        send_tick();

        configure(1'b0, kra_pkg::DELAY_RST, kra_pkg::PERIOD_RST);
        send_key(103, kra_pkg::VAL_PRESS);
        repeat (400) send_tick();
        send_key(103, kra_pkg::VAL_RELEASE);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 29 : (phase == 1) ? 87 : 0;
            recv_idle = (phase == 0) ? 87 : (phase == 1) ? 29 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                if (phase == 0 && blk == 1) begin
                    configure(1'b1, '0, '0);
                end else if (phase == 1 && blk == 1) begin
                    configure(1'b0, '1, '1);
                end else begin
                    configure(1'($urandom_range(1)), t_cfg'($urandom_range(24)),
                              t_cfg'($urandom_range(6)));
                end
                if (phase == 0 && blk == 0) begin
                    hold_off_req = 1'b1;
                    repeat (40) send_key(mapped_codes[$urandom_range(16)],
                                         kra_pkg::VAL_PRESS);
                end
                random_traffic(requests_sent + 50);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("key_remap_autorepeat_core verification clean");
        end else begin
            if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
            $display("key_remap_autorepeat_core verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/kra_pkg.sv
rtl/kra_keymap.sv
rtl/kra_repeat.sv
rtl/key_remap_autorepeat_core.sv
sim/key_remap_autorepeat_checker.sv
sim/key_remap_autorepeat_core_test.sv
